FILE: design/b32lpe_pkg.sv
// Shared types and constants for the left-padded base32 encoder.
// Holds the symbol alphabet lookup and the symbol group struct; no dependencies.
`default_nettype none

package b32lpe_pkg;

    localparam int unsigned SymBits  = 5;
    localparam int unsigned MaxPad   = 4;
    localparam int unsigned QueueDep = 4;

    // one encoded symbol as it leaves the block
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } sym_t;

    // up to three symbols produced by one input byte
    typedef struct packed {
        logic [1:0]       cnt;
        sym_t [2:0]       sym;
    } grp_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_PAD_BITS = 1'b0,
        REG_NONE     = 1'b1
    } reg_idx_t;

    // alphabet "13456789abcdefghijkmnopqrstuwxyz"
    function automatic logic [7:0] sym_char(input logic [4:0] g);
        logic [7:0] c;
        begin
            case (g)
                5'd0:    c = 8'h31;
                5'd1:    c = 8'h33;
                5'd2:    c = 8'h34;
                5'd3:    c = 8'h35;
                5'd4:    c = 8'h36;
                5'd5:    c = 8'h37;
                5'd6:    c = 8'h38;
                5'd7:    c = 8'h39;
                5'd8:    c = 8'h61;
                5'd9:    c = 8'h62;
                5'd10:   c = 8'h63;
                5'd11:   c = 8'h64;
                5'd12:   c = 8'h65;
                5'd13:   c = 8'h66;
                5'd14:   c = 8'h67;
                5'd15:   c = 8'h68;
                5'd16:   c = 8'h69;
                5'd17:   c = 8'h6a;
                5'd18:   c = 8'h6b;
                5'd19:   c = 8'h6d;
                5'd20:   c = 8'h6e;
                5'd21:   c = 8'h6f;
                5'd22:   c = 8'h70;
                5'd23:   c = 8'h71;
                5'd24:   c = 8'h72;
                5'd25:   c = 8'h73;
                5'd26:   c = 8'h74;
                5'd27:   c = 8'h75;
                5'd28:   c = 8'h77;
                5'd29:   c = 8'h78;
                5'd30:   c = 8'h79;
                default: c = 8'h7a;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/b32lpe_pack.sv
// Bit regrouping slice: merges carried bits with a new byte and cuts 5-bit symbols.
// Holds the leftover bit state across a message; depends on b32lpe_pkg.
`default_nettype none

module b32lpe_pack (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    input  wire logic [2:0]       pad_bits,
    output b32lpe_pkg::grp_t      grp
);
    import b32lpe_pkg::*;

    logic [3:0]  lo_val_reg, lo_val_next;
    logic [2:0]  lo_cnt_reg, lo_cnt_next;
    logic        start_reg, start_next;

    logic [2:0]  cnt0;
    logic [11:0] acc;
    logic [3:0]  total;
    logic [11:0] aligned;
    logic        two;
    logic [2:0]  rem;
    logic [4:0]  mask;
    logic [4:0]  g0, g1, g2;

    always_comb
    begin
        if (start_reg)
        begin
            cnt0 = (pad_bits > 3'(MaxPad)) ? 3'(MaxPad) : pad_bits;
            acc  = {4'b0, data_byte};
        end
        else
        begin
            cnt0 = lo_cnt_reg;
            acc  = {lo_val_reg, data_byte};
        end
        total   = {1'b0, cnt0} + 4'd8;
        // left-align the valid bits; the low end fills with zeros
        aligned = acc << (4'd12 - total);
        g0      = aligned[11:7];
        g1      = aligned[6:2];
        g2      = {aligned[1:0], 3'b0};
        two     = (total >= 4'd10);
        rem     = two ? 3'(total - 4'd10) : 3'(total - 4'd5);
        mask    = (5'd1 << rem) - 5'd1;

        grp.sym[0].ch   = sym_char(g0);
        grp.sym[0].last = 1'b0;
        grp.sym[1].ch   = sym_char(g1);
        grp.sym[1].last = last_byte && (!two || (rem == 3'd0));
        grp.sym[2].ch   = sym_char(g2);
        grp.sym[2].last = last_byte;

        if (!two)
            grp.cnt = last_byte ? 2'd2 : 2'd1;
        else
            grp.cnt = (last_byte && (rem != 3'd0)) ? 2'd3 : 2'd2;

        lo_val_next = lo_val_reg;
        lo_cnt_next = lo_cnt_reg;
        start_next  = start_reg;
        if (fire)
        begin
            if (last_byte)
            begin
                lo_val_next = 4'b0;
                lo_cnt_next = 3'b0;
                start_next  = 1'b1;
            end
            else
            begin
                lo_val_next = acc[3:0] & mask[3:0];
                lo_cnt_next = rem;
                start_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_val_reg <= 4'b0;
            lo_cnt_reg <= 3'b0;
            start_reg  <= 1'b1;
        end
        else
        begin
            lo_val_reg <= lo_val_next;
            lo_cnt_reg <= lo_cnt_next;
            start_reg  <= start_next;
        end
    end

`ifndef ASSERT_OFF
    a_lo_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        lo_cnt_reg <= 3'd4)
        else $error("leftover count out of range");
    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> (lo_cnt_reg == 3'd0 && lo_val_reg == 4'd0))
        else $error("leftover bits held at message start");
    a_last_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_byte) |=> start_reg)
        else $error("last byte did not close the message");
`endif

endmodule

`default_nettype wire

FILE: design/b32lpe_queue.sv
// Symbol queue: four registered entries that take a whole symbol group per
// transfer and release one symbol per cycle while sym_stall is low; depends on b32lpe_pkg.
`default_nettype none

module b32lpe_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  b32lpe_pkg::grp_t      grp,
    output logic                  full,
    output logic                  sym_valid,
    input  wire logic             sym_stall,
    output logic [7:0]            symbol_char,
    output logic                  last_symbol
);
    import b32lpe_pkg::*;

    sym_t       ent_reg  [QueueDep];
    sym_t       ent_next [QueueDep];
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [2:0] base;
    logic [2:0] off;

    assign sym_valid   = (cnt_reg != 3'd0);
    assign symbol_char = ent_reg[0].ch;
    assign last_symbol = ent_reg[0].last;
    assign full        = (cnt_reg > 3'd1);
    assign pop         = sym_valid && !sym_stall;

    always_comb
    begin
        base     = cnt_reg - {2'b0, pop};
        off      = 3'd0;
        ent_next = ent_reg;
        // advance toward the head on a transfer out
        if (pop)
        begin
            for (int i = 0; i < QueueDep - 1; i++)
                ent_next[i] = ent_reg[i + 1];
        end
        for (int i = 0; i < QueueDep; i++)
        begin
            off = 3'(i) - base;
            if (push && (3'(i) >= base) && (off < {1'b0, grp.cnt}))
            begin
                case (off[1:0])
                    2'd0:    ent_next[i] = grp.sym[0];
                    2'd1:    ent_next[i] = grp.sym[1];
                    default: ent_next[i] = grp.sym[2];
                endcase
            end
        end
        cnt_next = base + (push ? {1'b0, grp.cnt} : 3'd0);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QueueDep; i++)
            ent_reg[i] <= ent_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_next;
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(QueueDep))
        else $error("symbol queue overflow");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg <= 3'd1 && grp.cnt != 2'd0))
        else $error("group pushed without room");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (!push && pop) |=> (cnt_reg == $past(cnt_reg) - 3'd1))
        else $error("queue count lost track of a transfer");
`endif

endmodule

`default_nettype wire

FILE: design/base32_left_padded_encoder.sv
// With the queue empty, the first symbol of a byte is offered in the cycle after its transfer.
// Input flow: a byte is taken in any cycle where at most one symbol waits;
// the sustained byte rate (8 symbols per 5 bytes) is set by the
// single symbol output port draining the four-entry symbol queue.
// Reset (rst_n low, asynchronous): queue empty, no carried bits, next byte
// opens a message, pad_bits reads 0.
`default_nettype none

module base32_left_padded_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             sym_valid,
    input  wire logic        sym_stall,
    output logic [7:0]       symbol_char,
    output logic             last_symbol
);
    import b32lpe_pkg::*;

    logic [2:0] pad_reg, pad_next;
    reg_idx_t   idx;
    logic       fire;
    logic       full;
    grp_t       grp;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[2]);

    always_comb
    begin
        pad_next = pad_reg;
        if (psel && penable && pwrite && (idx == REG_PAD_BITS))
            pad_next = pwdata[2:0];
        unique case (idx)
            REG_PAD_BITS: prdata = {29'b0, pad_reg};
            default:      prdata = 32'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pad_reg <= 3'd0;
        else
            pad_reg <= pad_next;
    end

    assign item_stall = full;
    assign fire       = item_valid && !full;

    b32lpe_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .pad_bits  (pad_reg),
        .grp       (grp)
    );

    b32lpe_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (fire),
        .grp         (grp),
        .full        (full),
        .sym_valid   (sym_valid),
        .sym_stall   (sym_stall),
        .symbol_char (symbol_char),
        .last_symbol (last_symbol)
    );

endmodule

`default_nettype wire
